// File: rtl/pid_controller_izone_macros.svh
// Assertion shorthands for the PID block, clocked on clk and held off by rst.
`ifndef PID_CONTROLLER_IZONE_MACROS_SVH
`define PID_CONTROLLER_IZONE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define PCI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pci_pkg.sv
`default_nettype none

package pci_pkg;

  localparam int DATA_W     = 16;
  localparam int ERR_W      = DATA_W + 1;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int MUL_W      = 32;
  localparam int DERIV_FRAC = 16;
  localparam int DIV_W      = DATA_W + DERIV_FRAC;
  localparam int V_W        = 64;
  localparam int PROD_E_W   = DATA_W + TIME_W;

  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int INTEGRAL_WIDTH_DEF = 48;

  localparam logic [V_W-1:0] I_CLAMP = V_W'(1) << 60;

  localparam logic signed [DATA_W-1:0] DRIVE_POS_SAT = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] DRIVE_NEG_SAT = 16'sh8000;

  localparam logic ACT_STEP    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_INNER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_OUTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE      = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL_P,
    ST_MUL_E,
    ST_INTEG,
    ST_IMAG,
    ST_MUL_I0,
    ST_MUL_I1,
    ST_IACC,
    ST_IADD,
    ST_DIV_WAIT,
    ST_MUL_D,
    ST_DSUB,
    ST_MAG,
    ST_LIM,
    ST_EMIT
  } pci_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pci_div_stat_t;

endpackage

`default_nettype wire

// File: rtl/pci_mul.sv
`default_nettype none

module pci_mul
  import pci_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_W-1:0]   a,
  input  wire logic [MUL_W-1:0]   b,
  output logic      [2*MUL_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// File: rtl/pci_div.sv
`default_nettype none

module pci_div
  import pci_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic      [DIV_W-1:0] quotient,
  output pci_div_stat_t         stat
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   shifted;
  logic             fits;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quotient[DIV_W-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DIV_W'(shifted - {1'b0, dvs}) : shifted[DIV_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: rtl/pid_controller_izone.sv
// PID controller with an integration window and drive magnitude limits.
//
// Item channel: item_valid / item_stall carry action, setpoint, measured
// and now_ms. The block takes one item, works on it, then takes the next;
// item_stall is high for the whole of that work.
// Result channel: result_valid / result_stall carry ran and drive from one
// output register, so the next item is taken while a result still waits.
// From item transfer to result_valid: a restart or skipped step goes
// from setup straight to the result, a proportional-only step adds the
// proportional product and the limits, and a full PID step adds the
// integral terms and, but on a first run, which has no derivative, the
// 32-step bit-serial divider that forms the derivative. One shared 32x32
// multiplier, one product per cycle, forms all products. A new item is
// taken only when the last is done; a stalled result holds its value and
// the block waits to load its next result until that one transfers.
// Configuration: cfg_we writes cfg_data into register cfg_index; the user
// must write only while the block is idle, which the block does not enforce.
// Reset (rst, synchronous): gains 0, limits disabled, history cleared,
// first-run set, no result pending.
`default_nettype none
`include "pid_controller_izone_macros.svh"

module pid_controller_izone
  import pci_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic                     action,
  input  wire logic signed [DATA_W-1:0] setpoint,
  input  wire logic signed [DATA_W-1:0] measured,
  input  wire logic [TIME_W-1:0]        now_ms,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic                          ran,
  output logic signed [DATA_W-1:0]      drive
);

  localparam int IW    = INTEGRAL_WIDTH;
  localparam int SUM_W = ((IW > PROD_E_W + 1) ? IW : PROD_E_W + 1) + 1;
  localparam int ACC_W = 2 * MUL_W + GAIN_W + 1;
  localparam logic signed [SUM_W-1:0] INT_LIM =
    {{(SUM_W - IW + 1){1'b0}}, {(IW - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] INT_LIM_NEG = -INT_LIM;

  // configuration
  logic [GAIN_W-1:0]        gain_p, gain_i, gain_d;
  logic signed [ERR_W-1:0]  integral_inner, integral_outer;
  logic signed [DATA_W-1:0] min_drive, max_drive;

  // controller history
  logic [TIME_W-1:0]        last_time;
  logic signed [DATA_W-1:0] last_measured;
  logic signed [ERR_W-1:0]  current_error;
  logic signed [IW-1:0]     integral_sum;
  logic                     first_pass;
  logic signed [DATA_W-1:0] held_drive;

  // item and work registers
  pci_state_t               state, state_next;
  logic                     act_r;
  logic signed [DATA_W-1:0] sp_r, ms_r;
  logic [TIME_W-1:0]        now_r;
  logic [DATA_W-1:0]        err_mag;
  logic                     err_neg;
  logic [TIME_W-1:0]        dt_r;
  logic                     pid_mode, use_deriv, integ_en, deriv_neg, ran_r;
  logic signed [V_W-1:0]    vacc;
  logic [ACC_W-1:0]         acc;
  logic [IW-1:0]            imag;
  logic                     int_neg;
  logic [V_W-1:0]           vmag;
  logic                     v_neg;

  // shared units
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [2*MUL_W-1:0]       mul_p;
  logic                     div_start;
  logic [DIV_W-1:0]         div_quo;
  pci_div_stat_t            div_stat;

  // setup decode
  logic signed [ERR_W-1:0]  err_s, diff_s, err_abs, diff_abs;
  logic [TIME_W-1:0]        dt;
  logic                     pid_now, restart, skip, sign_change, window, both_off;
  logic signed [ERR_W-1:0]  mag_s;

  // integral update
  logic [SUM_W-1:0]         prod_ext;
  logic signed [SUM_W-1:0]  addend, sum;

  // term shaping
  logic [2*MUL_W-1:0]       imag_ext;
  logic [V_W-1:0]           iterm, dterm, lo, hi, m1, m2, q;
  logic                     emit_now;

  pci_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  pci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_abs[DATA_W-1:0], {DERIV_FRAC{1'b0}}}),
    .divisor  (dt),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    err_s       = {sp_r[DATA_W-1], sp_r} - {ms_r[DATA_W-1], ms_r};
    diff_s      = {ms_r[DATA_W-1], ms_r} - {last_measured[DATA_W-1], last_measured};
    err_abs     = err_s[ERR_W-1] ? -err_s : err_s;
    diff_abs    = diff_s[ERR_W-1] ? -diff_s : diff_s;
    dt          = now_r - last_time;
    pid_now     = (gain_i != '0) || (gain_d != '0);
    restart     = act_r == ACT_RESTART;
    skip        = !restart && pid_now && !first_pass && (dt == '0);
    sign_change = (err_s[ERR_W-1] != current_error[ERR_W-1]) ||
                  ((err_s == '0) != (current_error == '0));
    mag_s       = $signed({1'b0, err_abs[DATA_W-1:0]});
    window      = (err_abs != '0) && (mag_s > integral_inner) &&
                  (mag_s < integral_outer);
    both_off    = integral_inner[ERR_W-1] && integral_outer[ERR_W-1];
  end

  always_comb begin
    prod_ext = SUM_W'(mul_p[PROD_E_W-1:0]);
    addend   = err_neg ? -$signed(prod_ext) : $signed(prod_ext);
    sum      = SUM_W'(integral_sum) + addend;
    imag_ext = (2 * MUL_W)'(imag);
    iterm    = (acc > ACC_W'(I_CLAMP)) ? I_CLAMP : acc[V_W-1:0];
    dterm    = mul_p >> DERIV_FRAC;
    lo       = V_W'(min_drive[DATA_W-2:0]) << GAIN_FRAC_BITS;
    hi       = V_W'(max_drive[DATA_W-2:0]) << GAIN_FRAC_BITS;
    m1       = (!min_drive[DATA_W-1] && (vmag != '0) && (vmag < lo)) ? lo : vmag;
    m2       = (!max_drive[DATA_W-1] && (m1 > hi)) ? hi : m1;
    q        = m2 >> GAIN_FRAC_BITS;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (item_valid) state_next = ST_SETUP;
      ST_SETUP:    state_next = (restart || skip) ? ST_EMIT : ST_MUL_P;
      ST_MUL_P:    state_next = ST_MUL_E;
      ST_MUL_E:    state_next = pid_mode ? ST_INTEG : ST_MAG;
      ST_INTEG:    state_next = ST_IMAG;
      ST_IMAG:     state_next = ST_MUL_I0;
      ST_MUL_I0:   state_next = ST_MUL_I1;
      ST_MUL_I1:   state_next = ST_IACC;
      ST_IACC:     state_next = ST_IADD;
      ST_IADD:     state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!use_deriv) state_next = ST_MAG;
        else if (div_stat.done) state_next = ST_MUL_D;
      end
      ST_MUL_D:    state_next = ST_DSUB;
      ST_DSUB:     state_next = ST_MAG;
      ST_MAG:      state_next = ST_LIM;
      ST_LIM:      state_next = ST_EMIT;
      ST_EMIT:     if (emit_now) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    item_stall = state != ST_IDLE;
    emit_now   = (state == ST_EMIT) && (!result_valid || !result_stall);
    div_start  = (state == ST_SETUP) && !restart && !skip && pid_now && !first_pass;
    unique case (state)
      ST_MUL_P: begin
        mul_a = MUL_W'(err_mag);
        mul_b = MUL_W'(gain_p);
      end
      ST_MUL_E: begin
        mul_a = MUL_W'(err_mag);
        mul_b = MUL_W'(dt_r);
      end
      ST_MUL_I0: begin
        mul_a = imag_ext[MUL_W-1:0];
        mul_b = MUL_W'(gain_i);
      end
      ST_MUL_I1: begin
        mul_a = imag_ext[2*MUL_W-1:MUL_W];
        mul_b = MUL_W'(gain_i);
      end
      ST_MUL_D: begin
        mul_a = MUL_W'(div_quo);
        mul_b = MUL_W'(gain_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_inner <= '1;
      integral_outer <= '1;
      min_drive      <= '1;
      max_drive      <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:         gain_p         <= cfg_data;
        REG_GAIN_I:         gain_i         <= cfg_data;
        REG_GAIN_D:         gain_d         <= cfg_data;
        REG_INTEGRAL_INNER: integral_inner <= cfg_data[ERR_W-1:0];
        REG_INTEGRAL_OUTER: integral_outer <= cfg_data[ERR_W-1:0];
        REG_MIN_DRIVE:      min_drive      <= cfg_data[DATA_W-1:0];
        REG_MAX_DRIVE:      max_drive      <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // history
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time     <= '0;
      last_measured <= '0;
      current_error <= '0;
      integral_sum  <= '0;
      first_pass    <= 1'b1;
      held_drive    <= '0;
    end else begin
      if (state == ST_SETUP) begin
        if (restart) begin
          current_error <= '0;
          integral_sum  <= '0;
          last_measured <= '0;
          last_time     <= now_r;
          first_pass    <= 1'b1;
        end else if (!skip) begin
          if (pid_now) begin
            last_time <= now_r;
            if (sign_change) integral_sum <= '0;
          end
          current_error <= err_s;
          last_measured <= ms_r;
          first_pass    <= 1'b0;
        end
      end
      if (state == ST_INTEG && integ_en) begin
        if (sum > INT_LIM) integral_sum <= INT_LIM[IW-1:0];
        else if (sum < INT_LIM_NEG) integral_sum <= INT_LIM_NEG[IW-1:0];
        else integral_sum <= sum[IW-1:0];
      end
      if (state == ST_LIM) begin
        if (v_neg) begin
          held_drive <= (q >= V_W'(32768)) ? DRIVE_NEG_SAT : DATA_W'(-q[DATA_W-1:0]);
        end else begin
          held_drive <= (q > V_W'(32767)) ? DRIVE_POS_SAT : $signed(q[DATA_W-1:0]);
        end
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      act_r <= action;
      sp_r  <= setpoint;
      ms_r  <= measured;
      now_r <= now_ms;
    end
    case (state)
      ST_SETUP: begin
        err_mag   <= err_abs[DATA_W-1:0];
        err_neg   <= err_s[ERR_W-1];
        dt_r      <= dt;
        pid_mode  <= pid_now;
        use_deriv <= pid_now && !first_pass;
        integ_en  <= window || both_off;
        deriv_neg <= diff_s[ERR_W-1];
        ran_r     <= !restart && !skip;
      end
      ST_MUL_E:  vacc <= err_neg ? -$signed(mul_p) : $signed(mul_p);
      ST_IMAG: begin
        int_neg <= integral_sum[IW-1];
        imag    <= integral_sum[IW-1] ? IW'(-integral_sum) : IW'(integral_sum);
      end
      ST_MUL_I1: acc <= ACC_W'(mul_p);
      ST_IACC:   acc <= acc + (ACC_W'(mul_p) << MUL_W);
      ST_IADD:   vacc <= int_neg ? vacc - $signed(iterm) : vacc + $signed(iterm);
      ST_DSUB:   vacc <= deriv_neg ? vacc + $signed(dterm) : vacc - $signed(dterm);
      ST_MAG: begin
        v_neg <= vacc[V_W-1];
        vmag  <= vacc[V_W-1] ? V_W'(-vacc) : V_W'(vacc);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_now) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      ran   <= ran_r;
      drive <= held_drive;
    end
  end

  `PCI_ASSERT_NEXT(a_busy_after_transfer, item_valid && !item_stall, item_stall,
    "item taken but block did not go busy")
  `PCI_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy,
    "divider started while busy")
  `PCI_ASSERT_IMP(a_result_from_emit, $rose(result_valid), $past(state) == ST_EMIT,
    "result loaded outside emit")
  `PCI_ASSERT_IMP(a_skip_holds_integral, $past(state) == ST_EMIT && !$past(ran_r) &&
    $past(act_r) == ACT_STEP, $stable(integral_sum),
    "skipped step changed the integral")

endmodule

`default_nettype wire

// File: verif/pid_controller_izone_checker.sv
`timescale 1ns / 1ps

module pid_controller_izone_checker
  import pci_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic                     action,
  input  logic signed [DATA_W-1:0] setpoint,
  input  logic signed [DATA_W-1:0] measured,
  input  logic [TIME_W-1:0]        now_ms,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic                     ran,
  input  logic signed [DATA_W-1:0] drive,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic                     ran;
    logic signed [DATA_W-1:0] drive;
  } drive_result_t;

  drive_result_t expected_drives[$];

  logic [GAIN_W-1:0] kp, ki, kd;
  longint            izone_lo, izone_hi, drive_min, drive_max;

  logic [TIME_W-1:0]        prev_time;
  longint                   prev_meas, prev_err, integ_acc;
  bit                       first_run;
  logic signed [DATA_W-1:0] held;
  int                       errs;

  function automatic longint unsigned abs64(input longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint signed_mag(input longint unsigned m, input bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic int sign_of(input longint x);
    if (x > 0) return 1;
    if (x < 0) return -1;
    return 0;
  endfunction

  function automatic drive_result_t compute_drive(input logic act,
                                                  input logic signed [DATA_W-1:0] sp,
                                                  input logic signed [DATA_W-1:0] ms,
                                                  input logic [TIME_W-1:0] now);
    longint            err, v, deriv, iterm, dterm, prod, lim, diff, lo, hi, gp;
    longint unsigned   m, q;
    logic [TIME_W-1:0] dt;
    drive_result_t     res;
    err = longint'(sp) - longint'(ms);
    lim = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
    gp = longint'({40'd0, kp});
    res.ran = 1'b0;
    res.drive = held;
    if (act == ACT_RESTART) begin
      prev_err = 0;
      integ_acc = 0;
      prev_meas = 0;
      prev_time = now;
      first_run = 1'b1;
      return res;
    end
    if (ki != 0 || kd != 0) begin
      dt = now - prev_time;
      if (!first_run && dt == 0) return res;
      prev_time = now;
      deriv = 0;
      if (!first_run) begin
        diff = longint'(ms) - prev_meas;
        deriv = signed_mag((abs64(diff) << DERIV_FRAC) / {32'd0, dt}, diff < 0);
      end
      if (sign_of(err) != sign_of(prev_err)) integ_acc = 0;
      prev_err = err;
      if ((abs64(err) > 0 && longint'(abs64(err)) > izone_lo &&
           longint'(abs64(err)) < izone_hi) || (izone_lo < 0 && izone_hi < 0)) begin
        prod = err * longint'({32'd0, dt});
        if (prod > 0 && integ_acc > lim - prod) integ_acc = lim;
        else if (prod < 0 && integ_acc < -lim - prod) integ_acc = -lim;
        else integ_acc = integ_acc + prod;
      end
      m = abs64(integ_acc);
      if (ki != 0 && m > I_CLAMP / ki) iterm = signed_mag(I_CLAMP, integ_acc < 0);
      else iterm = signed_mag(m * ki, integ_acc < 0);
      dterm = signed_mag((abs64(deriv) * kd) >> DERIV_FRAC, deriv < 0);
      v = err * gp + iterm - dterm;
    end else begin
      prev_err = err;
      v = err * gp;
    end
    prev_meas = ms;
    first_run = 1'b0;
    if (drive_min >= 0) begin
      lo = drive_min <<< GAIN_FRAC_BITS;
      if (abs64(v) < longint'(lo)) v = sign_of(v) * lo;
    end
    if (drive_max >= 0) begin
      hi = drive_max <<< GAIN_FRAC_BITS;
      if (abs64(v) > longint'(hi)) v = sign_of(v) * hi;
    end
    q = abs64(v) >> GAIN_FRAC_BITS;
    if (v < 0) res.drive = (q >= 32768) ? DRIVE_NEG_SAT : DATA_W'(-longint'(q));
    else res.drive = (q > 32767) ? DRIVE_POS_SAT : DATA_W'(q);
    held = res.drive;
    res.ran = 1'b1;
    return res;
  endfunction

  initial begin
    errs = 0;
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    drive_result_t exp_res;
    if (rst) begin
      kp = '0;
      ki = '0;
      kd = '0;
      izone_lo = -1;
      izone_hi = -1;
      drive_min = -1;
      drive_max = -1;
      prev_time = '0;
      prev_meas = 0;
      prev_err = 0;
      integ_acc = 0;
      first_run = 1'b1;
      held = '0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:         kp = cfg_data;
          REG_GAIN_I:         ki = cfg_data;
          REG_GAIN_D:         kd = cfg_data;
          REG_INTEGRAL_INNER: izone_lo = longint'($signed(cfg_data[16:0]));
          REG_INTEGRAL_OUTER: izone_hi = longint'($signed(cfg_data[16:0]));
          REG_MIN_DRIVE:      drive_min = longint'($signed(cfg_data[15:0]));
          REG_MAX_DRIVE:      drive_max = longint'($signed(cfg_data[15:0]));
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        expected_drives.push_back(compute_drive(action, setpoint, measured, now_ms));
      if (result_valid && !result_stall) begin
        if (expected_drives.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual ran=%0b drive=%0d",
                   $time, ran, drive);
          errs++;
        end else begin
          exp_res = expected_drives.pop_front();
          if (exp_res.ran !== ran) begin
            $display("%0t: ran mismatch, expected %0b actual %0b", $time, exp_res.ran, ran);
            errs++;
          end
          if (exp_res.drive !== drive) begin
            $display("%0t: drive mismatch, expected %0d actual %0d",
                     $time, $signed(exp_res.drive), drive);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    pending <= expected_drives.size();
  end

endmodule

// File: verif/tb_pid_controller_izone.sv
`timescale 1ns / 1ps

module tb_pid_controller_izone
  import pci_pkg::*;
();

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES           = 10;
  localparam int PHASE_ITEMS      = 50;
  localparam logic [CFG_DATA_W-1:0] OFF = '1;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     item_valid;
  logic                     item_stall;
  logic                     action;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;
  logic [TIME_W-1:0]        now_ms;
  logic                     result_valid;
  logic                     result_stall;
  logic                     ran;
  logic signed [DATA_W-1:0] drive;

  int          fail_count;
  int          pending_results;
  int          cycle_count;
  bit          calm;
  bit          long_hold;
  logic [31:0] t_now;

  pid_controller_izone DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .setpoint     (setpoint),
    .measured     (measured),
    .now_ms       (now_ms),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ran          (ran),
    .drive        (drive)
  );

  pid_controller_izone_checker pid_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .setpoint     (setpoint),
    .measured     (measured),
    .now_ms       (now_ms),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ran          (ran),
    .drive        (drive),
    .fail_count   (fail_count),
    .pending      (pending_results)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly short, a few long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(0, 24'h03FFFF));
      2: return CFG_DATA_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_zone();
    case ($urandom_range(0, 5))
      0, 1: return OFF;
      2: return CFG_DATA_W'($urandom_range(0, 2000));
      3: return CFG_DATA_W'($urandom_range(0, 65535));
      4: return CFG_DATA_W'(65535);
      default: return '0;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_drive_limit();
    case ($urandom_range(0, 5))
      0, 1, 2: return OFF;
      3: return CFG_DATA_W'($urandom_range(0, 50));
      4: return CFG_DATA_W'($urandom_range(0, 32767));
      default: return CFG_DATA_W'(32767);
    endcase
  endfunction

  // receiver: random stalls, long hold-off on request
  initial begin
    int   len;
    logic level;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        level = 1'b1;
        len = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end else if (calm) begin
        level = 1'b0;
        len = 1;
      end else begin
        level = ($urandom_range(0, 99) < 35);
        len = pick_len();
      end
      result_stall <= level;
      repeat (len - 1) @(negedge clk);
    end
  end

  task automatic send_item(input logic act, input int sp, input int ms, input logic [31:0] t);
    int n;
    @(negedge clk);
    item_valid <= 1'b1;
    action <= act;
    setpoint <= DATA_W'(sp);
    measured <= DATA_W'(ms);
    now_ms <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    n = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_len();
    if (n > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] gp, gi, gd, lo, hi, mn, mx);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_INTEGRAL_INNER, lo);
    write_reg(REG_INTEGRAL_OUTER, hi);
    write_reg(REG_MIN_DRIVE, mn);
    write_reg(REG_MAX_DRIVE, mx);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] gi, gd;
    gi = pick_gain();
    gd = pick_gain();
    if ($urandom_range(0, 3) == 0) begin
      gi = '0;
      gd = '0;
    end
    write_regs(pick_gain(), gi, gd, pick_zone(), pick_zone(),
               pick_drive_limit(), pick_drive_limit());
  endtask

  // mostly a well-behaved loop: time moving forward, measurement near target
  task automatic random_item();
    int   r, sp, ms;
    logic act;
    act = ($urandom_range(0, 99) < 6) ? ACT_RESTART : ACT_STEP;
    r = $urandom_range(0, 99);
    if (r < 12) t_now = t_now;
    else if (r < 80) t_now = t_now + $urandom_range(1, 3);
    else if (r < 95) t_now = t_now + $urandom_range(4, 1000);
    else t_now = $urandom;
    if ($urandom_range(0, 99) < 30) begin
      sp = int'($urandom);
      ms = int'($urandom);
    end else begin
      sp = int'($urandom_range(0, 600)) - 300;
      ms = sp + int'($urandom_range(0, 400)) - 200;
    end
    send_item(act, sp, ms, t_now);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    action = ACT_STEP;
    setpoint = '0;
    measured = '0;
    now_ms = '0;
    calm = 1'b0;
    long_hold = 1'b0;
    t_now = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: zero gains
    send_item(ACT_STEP, 12345, -12345, 32'd0);
    send_item(ACT_RESTART, 0, 0, 32'd7);
    drain();

    // full PID, no window: integral overflow on a huge first interval, skip, wrap
    write_regs(24'h010000, 24'h000100, 24'h010000, OFF, OFF, OFF, OFF);
    send_item(ACT_STEP, 32767, -32768, 32'hFFFF_FFFF);
    send_item(ACT_STEP, 32767, -32768, 32'hFFFF_FFFF);
    send_item(ACT_STEP, -32768, 32767, 32'd0);
    send_item(ACT_STEP, 0, 0, 32'd3);
    send_item(ACT_STEP, 100, 40, 32'd4);
    send_item(ACT_RESTART, 0, 0, 32'd10);
    send_item(ACT_STEP, 5, 0, 32'd10);
    send_item(ACT_STEP, 5, 0, 32'd10);
    drain();

    // largest gains, widest window, min and max at their top
    write_regs('1, '1, '1, '0, CFG_DATA_W'(65535), CFG_DATA_W'(32767), CFG_DATA_W'(32767));
    send_item(ACT_STEP, 1, 0, 32'd20);
    send_item(ACT_STEP, -32768, 32767, 32'd21);
    send_item(ACT_STEP, 32767, -32768, 32'd22);
    send_item(ACT_STEP, 3, 3, 32'd23);
    drain();

    // proportional only with drive limits
    write_regs(24'h008000, '0, '0, CFG_DATA_W'(65535), OFF, CFG_DATA_W'(100),
               CFG_DATA_W'(200));
    send_item(ACT_STEP, 10, 0, 32'd30);
    send_item(ACT_STEP, 1000, 0, 32'd30);
    send_item(ACT_STEP, 0, 0, 32'd30);
    send_item(ACT_STEP, -300, 0, 32'd31);
    send_item(ACT_STEP, -32768, 32767, 32'd31);
    drain();

    // zero-width drive limits, empty window
    write_regs('1, '0, 24'h000001, OFF, '0, '0, '0);
    send_item(ACT_STEP, 32767, -32768, 32'd40);
    send_item(ACT_STEP, -5, 5, 32'd41);
    send_item(ACT_RESTART, 0, 0, 32'd50);

    t_now = 32'd50;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      random_config();
      calm = (phase % 4 == 1) || (phase == 3) || (phase == 7);
      if (phase == 3 || phase == 7) long_hold = 1'b1;
      if (phase == 5) t_now = 32'hFFFF_FFF0;
      for (int k = 0; k < PHASE_ITEMS; k++) random_item();
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pci_pkg.sv
rtl/pci_mul.sv
rtl/pci_div.sv
rtl/pid_controller_izone.sv
verif/pid_controller_izone_checker.sv
verif/tb_pid_controller_izone.sv
